FILE: rtl/core/reference_block_index_map_assert.svh
// ----------------------------------------------------------------------------
// reference_block_index_map assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REFERENCE_BLOCK_INDEX_MAP_ASSERT_SVH
`define REFERENCE_BLOCK_INDEX_MAP_ASSERT_SVH

// condition implies consequence in the same cycle
`define RBIM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RBIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rbim_pkg.sv
// ----------------------------------------------------------------------------
// rbim_pkg
// Widths, register codes, item types and helpers for the reference index map.
// ----------------------------------------------------------------------------
`default_nettype none

package rbim_pkg;

  localparam int LANE_W     = 24;
  localparam int SEG_W      = 30;
  localparam int COL_W      = 32;
  localparam int HALF_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  // remainder unit: 33-bit dividend, 32-bit divisor, one quotient bit per stage
  localparam int NUM_W      = 33;
  localparam int DEN_W      = 32;
  localparam int REM_STAGES = NUM_W;
  // area arithmetic, signed with headroom for column minus one
  localparam int AREA_W     = 35;
  localparam int OFF_STAGES = 3;

  localparam logic [LANE_W-1:0] LANE_COUNT_RST = LANE_W'(1);
  localparam logic [SEG_W-1:0]  SEG_LEN_RST    = SEG_W'(2);

  typedef enum logic {
    REG_LANE_COUNT = 1'b0,
    REG_SEG_LEN    = 1'b1
  } reg_idx_t;

  // fields that ride alongside the first remainder pass
  typedef struct packed {
    logic              first;
    logic [1:0]        slice;
    logic [LANE_W-1:0] cur_lane;
    logic [COL_W-1:0]  col;
    logic [HALF_W-1:0] lo;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [SEG_W-1:0]  pos;
    logic [LANE_W-1:0] lane_mod;
  } off_in_t;

  typedef struct packed {
    logic [NUM_W-1:0]  sum;
    logic [LANE_W-1:0] lane;
  } off_out_t;

  // k times the segment length, k in 0..7, by shifts and adds
  function automatic logic [SEG_W+2:0] seg_mul(input logic [2:0] k,
                                               input logic [SEG_W-1:0] s);
    logic [SEG_W+2:0] a;
    logic [SEG_W+2:0] b;
    logic [SEG_W+2:0] c;
    a = k[0] ? {3'b000, s}       : '0;
    b = k[1] ? {2'b00, s, 1'b0}  : '0;
    c = k[2] ? {1'b0, s, 2'b00}  : '0;
    return a + b + c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rbim_in_if.sv
// ----------------------------------------------------------------------------
// rbim_in_if
// Input channel: one index request word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbim_in_if;
  logic                      valid;
  logic                      ready;
  logic                      first_pass;
  logic [1:0]                slice;
  logic [rbim_pkg::LANE_W-1:0] current_lane;
  logic [rbim_pkg::COL_W-1:0]  column;
  logic [2*rbim_pkg::HALF_W-1:0] pseudo_random;

  modport source (
    output valid, first_pass, slice, current_lane, column, pseudo_random,
    input  ready
  );
  modport sink (
    input  valid, first_pass, slice, current_lane, column, pseudo_random,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rbim_out_if.sv
// ----------------------------------------------------------------------------
// rbim_out_if
// Result channel: reference lane and column with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbim_out_if;
  logic                        valid;
  logic                        ready;
  logic [rbim_pkg::LANE_W-1:0] ref_lane;
  logic [rbim_pkg::COL_W-1:0]  ref_column;

  modport source (
    output valid, ref_lane, ref_column,
    input  ready
  );
  modport sink (
    input  valid, ref_lane, ref_column,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/reference_block_index_map.sv
// ----------------------------------------------------------------------------
// reference_block_index_map
// Maps a 64-bit pseudo-random word to the lane and column of the reference
// block, through two pipelined remainder passes around a multiply datapath.
//
//   channel   dir  handshake       contents
//   in_ch     in   valid/ready     first_pass, slice, current_lane, column,
//                                  pseudo_random
//   out_ch    out  valid/ready     ref_lane, ref_column
//   apb       in   psel/penable    lane_count @0x0, seg_len @0x4
//
// One word per cycle sustained while out_ch does not stall; the result word
// passes through 71 register stages: input register, two 33-stage remainder
// pipes, three offset stages and the output register.
// Reset (rst_n low, synchronous) clears all valid bits and loads lane_count 1,
// seg_len 2. A stall on out_ch parks one word in a skid register and then
// freezes the whole pipe; in_ch.ready drops only while the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reference_block_index_map_assert.svh"

module reference_block_index_map (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rbim_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rbim_pkg::DATA_W-1:0]  pwdata,
  output logic      [rbim_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  rbim_in_if.sink                           in_ch,
  rbim_out_if.source                        out_ch
);

  // configuration registers
  logic [rbim_pkg::LANE_W-1:0] lane_count_r;
  logic [rbim_pkg::SEG_W-1:0]  seg_len_r;
  logic [rbim_pkg::LANE_W-1:0] lanes_eff;
  logic [rbim_pkg::SEG_W-1:0]  seg_eff;
  logic                        cfg_wr;

  // pipeline control
  logic pipe_en;

  // input stage
  logic                         s0_v_r;
  rbim_pkg::item_t              s0_item_r;
  logic [rbim_pkg::HALF_W-1:0]  s0_hi_r;

  // first remainder pass
  logic [rbim_pkg::REM_STAGES-1:0] va_r;
  rbim_pkg::item_t                 da_r [rbim_pkg::REM_STAGES];
  logic [rbim_pkg::DEN_W-1:0]      pos_rem;
  logic [rbim_pkg::DEN_W-1:0]      lane_rem;

  // offset stages
  logic [rbim_pkg::OFF_STAGES-1:0] vo_r;
  rbim_pkg::off_in_t               off_d;
  rbim_pkg::off_out_t              off_q;

  // final wrap by lane length
  logic [rbim_pkg::REM_STAGES-1:0] vb_r;
  logic [rbim_pkg::LANE_W-1:0]     lb_r [rbim_pkg::REM_STAGES];
  logic [rbim_pkg::DEN_W-1:0]      col_rem;

  // output register and skid
  logic                        out_valid_r;
  logic [rbim_pkg::LANE_W-1:0] out_lane_r;
  logic [rbim_pkg::COL_W-1:0]  out_col_r;
  logic                        skid_valid_r;
  logic [rbim_pkg::LANE_W-1:0] skid_lane_r;
  logic [rbim_pkg::COL_W-1:0]  skid_col_r;
  logic                        tail_v;

  // register write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_count_r <= rbim_pkg::LANE_COUNT_RST;
      seg_len_r    <= rbim_pkg::SEG_LEN_RST;
    end else if (cfg_wr) begin
      case (rbim_pkg::reg_idx_t'(paddr[2]))
        rbim_pkg::REG_LANE_COUNT: lane_count_r <= pwdata[rbim_pkg::LANE_W-1:0];
        rbim_pkg::REG_SEG_LEN:    seg_len_r    <= pwdata[rbim_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rbim_pkg::reg_idx_t'(paddr[2]))
      rbim_pkg::REG_LANE_COUNT:
        prdata = rbim_pkg::DATA_W'(lane_count_r);
      rbim_pkg::REG_SEG_LEN:
        prdata = rbim_pkg::DATA_W'(seg_len_r);
      default:
        prdata = '0;
    endcase
  end

  // zero counts behave as one
  assign lanes_eff = (lane_count_r == '0) ? rbim_pkg::LANE_W'(1) : lane_count_r;
  assign seg_eff   = (seg_len_r == '0)    ? rbim_pkg::SEG_W'(1)  : seg_len_r;

  // whole pipe advances unless the skid holds a word
  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (pipe_en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_item_r.first    <= in_ch.first_pass;
      s0_item_r.slice    <= in_ch.slice;
      s0_item_r.cur_lane <= in_ch.current_lane;
      s0_item_r.col      <= in_ch.column;
      s0_item_r.lo       <= in_ch.pseudo_random[rbim_pkg::HALF_W-1:0];
      s0_hi_r            <= in_ch.pseudo_random[2*rbim_pkg::HALF_W-1:rbim_pkg::HALF_W];
    end
  end

  // column position in segment and lane pick, in parallel
  rbim_rem u_pos_rem (
    .clk (clk),
    .en  (pipe_en),
    .num ({1'b0, s0_item_r.col}),
    .den ({2'b00, seg_eff}),
    .rem (pos_rem)
  );

  rbim_rem u_lane_rem (
    .clk (clk),
    .en  (pipe_en),
    .num ({1'b0, s0_hi_r}),
    .den ({8'h00, lanes_eff}),
    .rem (lane_rem)
  );

  // valid and item fields alongside the first pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
    end else if (pipe_en) begin
      va_r <= {va_r[rbim_pkg::REM_STAGES-2:0], s0_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      da_r[0] <= s0_item_r;
      for (int i = 1; i < rbim_pkg::REM_STAGES; i++) begin
        da_r[i] <= da_r[i-1];
      end
    end
  end

  // area, square, scale and offset
  assign off_d.item     = da_r[rbim_pkg::REM_STAGES-1];
  assign off_d.pos      = pos_rem[rbim_pkg::SEG_W-1:0];
  assign off_d.lane_mod = lane_rem[rbim_pkg::LANE_W-1:0];

  rbim_offset u_offset (
    .clk (clk),
    .en  (pipe_en),
    .seg (seg_eff),
    .d   (off_d),
    .q   (off_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= '0;
    end else if (pipe_en) begin
      vo_r <= {vo_r[rbim_pkg::OFF_STAGES-2:0], va_r[rbim_pkg::REM_STAGES-1]};
    end
  end

  // wrap by lane length, four segments
  rbim_rem u_col_rem (
    .clk (clk),
    .en  (pipe_en),
    .num (off_q.sum),
    .den ({seg_eff, 2'b00}),
    .rem (col_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (pipe_en) begin
      vb_r <= {vb_r[rbim_pkg::REM_STAGES-2:0], vo_r[rbim_pkg::OFF_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lb_r[0] <= off_q.lane;
      for (int i = 1; i < rbim_pkg::REM_STAGES; i++) begin
        lb_r[i] <= lb_r[i-1];
      end
    end
  end

  assign tail_v = vb_r[rbim_pkg::REM_STAGES-1];

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= tail_v;
      end
    end else if (tail_v && pipe_en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_lane_r <= skid_lane_r;
        out_col_r  <= skid_col_r;
      end else begin
        out_lane_r <= lb_r[rbim_pkg::REM_STAGES-1];
        out_col_r  <= col_rem;
      end
    end else if (pipe_en) begin
      skid_lane_r <= lb_r[rbim_pkg::REM_STAGES-1];
      skid_col_r  <= col_rem;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ref_lane   = out_lane_r;
  assign out_ch.ref_column = out_col_r;

  // skid only ever sits behind a held result word
  `RBIM_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r,
                    "skid holds a word while the output register is empty")
  // skid fills only when the output word was stalled
  `RBIM_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_r),
                    $past(out_valid_r) && !$past(out_ch.ready),
                    "skid filled without an output stall")
  // a taken output drains the skid into the output register
  `RBIM_ASSERT_NEXT(a_skid_drain, skid_valid_r && out_ch.ready,
                    !skid_valid_r && out_valid_r,
                    "skid word not moved to output after a take")

endmodule

`default_nettype wire

FILE: rtl/core/rbim_rem.sv
// ----------------------------------------------------------------------------
// rbim_rem
// Pipelined restoring remainder, one dividend bit per stage, 33 stages.
// The caller must hold the divisor steady while words are in flight; not enforced here.
// ----------------------------------------------------------------------------
`default_nettype none

module rbim_rem (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [rbim_pkg::NUM_W-1:0]  num,
  input  wire logic [rbim_pkg::DEN_W-1:0]  den,
  output logic      [rbim_pkg::DEN_W-1:0]  rem
);

  logic [rbim_pkg::DEN_W-1:0] rem_r [rbim_pkg::REM_STAGES];
  logic [rbim_pkg::NUM_W-1:0] num_r [rbim_pkg::REM_STAGES-1];

  genvar gi;
  for (gi = 0; gi < rbim_pkg::REM_STAGES; gi++) begin : g_stage
    logic [rbim_pkg::DEN_W-1:0] rem_in;
    logic [rbim_pkg::NUM_W-1:0] num_in;
    logic [rbim_pkg::DEN_W:0]   cand;
    logic [rbim_pkg::DEN_W-1:0] rem_nxt;

    // partial remainder and dividend bits from the stage before
    if (gi == 0) begin : g_head
      assign rem_in = '0;
      assign num_in = num;
    end else begin : g_body
      assign rem_in = rem_r[gi-1];
      assign num_in = num_r[gi-1];
    end

    // shift in the next bit, subtract when it fits
    assign cand    = {rem_in, num_in[rbim_pkg::NUM_W-1-gi]};
    assign rem_nxt = (cand >= {1'b0, den}) ?
                     rbim_pkg::DEN_W'(cand - {1'b0, den}) : cand[rbim_pkg::DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi] <= rem_nxt;
      end
    end

    // dividend bits still needed downstream
    if (gi < rbim_pkg::REM_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[gi] <= num_in;
        end
      end
    end
  end

  assign rem = rem_r[rbim_pkg::REM_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/rbim_offset.sv
// ----------------------------------------------------------------------------
// rbim_offset
// Three-stage area sizing, squaring, scaling and offset of the reference
// column, ahead of the final wrap by lane length.
// ----------------------------------------------------------------------------
`default_nettype none

module rbim_offset (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rbim_pkg::SEG_W-1:0] seg,
  input  wire rbim_pkg::off_in_t          d,
  output rbim_pkg::off_out_t              q
);

  // stage 1 logic
  logic                                 same_lane;
  logic                                 pos_zero;
  logic                                 forced;
  logic [rbim_pkg::SEG_W+2:0]           base;
  logic [rbim_pkg::SEG_W+2:0]           start_full;
  logic signed [rbim_pkg::AREA_W-1:0]   area;
  logic [2*rbim_pkg::HALF_W-1:0]        sq_full;

  // stage registers
  logic [rbim_pkg::HALF_W-1:0]  s1_r_r;
  logic                         s1_live_r;
  logic [rbim_pkg::COL_W-1:0]   s1_start_r;
  logic [rbim_pkg::HALF_W-1:0]  s1_sq_r;
  logic [rbim_pkg::LANE_W-1:0]  s1_lane_r;

  logic [2*rbim_pkg::HALF_W-1:0] prod;
  logic [rbim_pkg::HALF_W-1:0]  s2_r_r;
  logic                         s2_live_r;
  logic [rbim_pkg::COL_W-1:0]   s2_start_r;
  logic [rbim_pkg::HALF_W-1:0]  s2_y_r;
  logic [rbim_pkg::LANE_W-1:0]  s2_lane_r;

  logic [rbim_pkg::COL_W-1:0]   z;
  logic [rbim_pkg::NUM_W-1:0]   s3_sum_r;
  logic [rbim_pkg::LANE_W-1:0]  s3_lane_r;

  // area size and start for this position
  always_comb begin
    same_lane  = (d.lane_mod == d.item.cur_lane);
    pos_zero   = (d.pos == '0);
    forced     = d.item.first && (d.item.slice == 2'd0);
    base       = d.item.first ? rbim_pkg::seg_mul({1'b0, d.item.slice}, seg)
                              : rbim_pkg::seg_mul(3'd3, seg);
    start_full = d.item.first ? '0
                              : rbim_pkg::seg_mul({1'b0, d.item.slice} + 3'd1, seg);
    if (forced) begin
      area = $signed({3'b000, d.item.col}) - 35'sd1;
    end else if (same_lane) begin
      area = $signed({2'b00, base}) + $signed({5'b00000, d.pos}) - 35'sd1;
    end else begin
      area = $signed({2'b00, base}) - $signed({34'b0, pos_zero});
    end
    sq_full = 64'(d.item.lo) * 64'(d.item.lo);
  end

  // stage 1: area registered, square of the low half
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r_r     <= area[rbim_pkg::HALF_W-1:0];
      s1_live_r  <= (area > 35'sd0);
      s1_start_r <= start_full[rbim_pkg::COL_W-1:0];
      s1_sq_r    <= sq_full[2*rbim_pkg::HALF_W-1:rbim_pkg::HALF_W];
      s1_lane_r  <= forced ? d.item.cur_lane : d.lane_mod;
    end
  end

  // stage 2: scale the square into the area
  assign prod = 64'(s1_r_r) * 64'(s1_sq_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r_r     <= s1_r_r;
      s2_live_r  <= s1_live_r;
      s2_start_r <= s1_start_r;
      s2_y_r     <= prod[2*rbim_pkg::HALF_W-1:rbim_pkg::HALF_W];
      s2_lane_r  <= s1_lane_r;
    end
  end

  // stage 3: distance back from the area end, plus area start
  assign z = s2_live_r ? (s2_r_r - 32'd1 - s2_y_r) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= {1'b0, z} + {1'b0, s2_start_r};
      s3_lane_r <= s2_lane_r;
    end
  end

  assign q.sum  = s3_sum_r;
  assign q.lane = s3_lane_r;

endmodule

`default_nettype wire
